[sv/sm3_pkg.sv]
// sm3_pkg: shared constants, types and register codes for the 3x3 smoothing filter
// no dependencies; imported by sm3_mac and symmetric_3x3_smoothing
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;

    // largest frame edge the line stores hold
    localparam int MAX_SIZE = 1024;
    localparam int MIN_SIZE = 3;
    localparam int ADDR_W   = $clog2(MAX_SIZE);
    localparam int CNT_W    = ADDR_W;
    localparam int SIZE_W   = ADDR_W + 1;

    // fixed field widths
    localparam int PIX_W   = 16;
    localparam int WGT_W   = 16;
    localparam int FSZ_W   = 11;
    localparam int DATA_W  = 16;
    localparam int IDX_W   = 3;

    // sum of four pixels, product of a sum and a weight, full accumulator
    localparam int SUM_W   = PIX_W + 2;
    localparam int PROD_W  = SUM_W + WGT_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 16;

    localparam logic [FSZ_W-1:0] RST_FRAME_SIZE = FSZ_W'(MAX_SIZE);
    localparam logic [WGT_W-1:0] RST_CORNER     = WGT_W'(3277);
    localparam logic [WGT_W-1:0] RST_ORTH       = WGT_W'(6554);
    localparam logic [WGT_W-1:0] RST_CENTER     = WGT_W'(26214);

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_SIZE = 3'd0,
        REG_CORNER     = 3'd1,
        REG_ORTH       = 3'd2,
        REG_CENTER     = 3'd3
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    // window[row][col], row 0 is the oldest line, col 0 the oldest column
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [WGT_W-1:0] corner;
        logic [WGT_W-1:0] orth;
        logic [WGT_W-1:0] center;
    } t_weights;

    typedef struct packed {
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last;
    } t_meta;

endpackage
`default_nettype wire

[sv/sm3_ram.sv]
// sm3_ram: generic simple dual-port RAM, one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sm3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/sm3_mac.sv]
// sm3_mac: weighted 3x3 sum, round and saturate, two register stages plus output register
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_mac (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire sm3_pkg::t_win     i_win,
    input  wire sm3_pkg::t_meta    i_meta,
    input  wire sm3_pkg::t_weights i_wgt,
    output logic                   o_valid,
    output sm3_pkg::t_pix          o_smoothed,
    output sm3_pkg::t_meta         o_meta
);
    import sm3_pkg::*;

    // stage 3: neighbor sums
    logic              r_vld3;
    logic [SUM_W-1:0]  r_cor_sum, n_cor_sum;
    logic [SUM_W-1:0]  r_orth_sum, n_orth_sum;
    t_pix              r_ctr;
    t_meta             r_meta3;

    // stage 4: products
    logic              r_vld4;
    logic [PROD_W-1:0] r_cor_prod;
    logic [PROD_W-1:0] r_orth_prod;
    logic [PROD_W-1:0] r_ctr_prod;
    t_meta             r_meta4;

    // output register
    logic              r_out_vld;
    t_pix              r_out_pix, n_out_pix;
    t_meta             r_out_meta;

    logic [ACC_W-1:0]  n_acc;

    always_comb begin
        n_cor_sum  = SUM_W'(i_win[0][0]) + SUM_W'(i_win[0][2])
                   + SUM_W'(i_win[2][0]) + SUM_W'(i_win[2][2]);
        n_orth_sum = SUM_W'(i_win[0][1]) + SUM_W'(i_win[2][1])
                   + SUM_W'(i_win[1][0]) + SUM_W'(i_win[1][2]);
    end

    // round to nearest by adding half an lsb, then clip at full scale
    always_comb begin
        n_acc = ACC_W'(r_cor_prod) + ACC_W'(r_orth_prod) + ACC_W'(r_ctr_prod)
              + ACC_W'(1 << (FRAC_W - 1));
        if (n_acc[ACC_W-1:FRAC_W+PIX_W] != '0) begin
            n_out_pix = '1;
        end else begin
            n_out_pix = n_acc[FRAC_W +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3    <= 1'b0;
            r_vld4    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld3    <= i_vld;
            r_vld4    <= r_vld3;
            r_out_vld <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cor_sum   <= n_cor_sum;
            r_orth_sum  <= n_orth_sum;
            r_ctr       <= i_win[1][1];
            r_meta3     <= i_meta;
            r_cor_prod  <= PROD_W'(r_cor_sum) * PROD_W'(i_wgt.corner);
            r_orth_prod <= PROD_W'(r_orth_sum) * PROD_W'(i_wgt.orth);
            r_ctr_prod  <= PROD_W'(r_ctr) * PROD_W'(i_wgt.center);
            r_meta4     <= r_meta3;
            r_out_pix   <= n_out_pix;
            r_out_meta  <= r_meta4;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_smoothed = r_out_pix;
    assign o_meta     = r_out_meta;

endmodule
`default_nettype wire

[sv/symmetric_3x3_smoothing.sv]
// symmetric_3x3_smoothing: top level of the streaming 3x3 smoothing filter
// depends on sm3_pkg, sm3_ram, sm3_mac
//
//  channel   | valid    | ready    | payload
//  ----------+----------+----------+-----------------------------------------------
//  pixel in  | i_valid  | o_ready  | i_pixel
//  result    | o_valid  | i_ready  | o_smoothed, o_out_row, o_out_col, o_frame_last
//  config    | i_cfg_we | (none)   | i_cfg_idx, i_cfg_data
//
//  one pixel per cycle while the output is not stalled; an accepted pixel's result passes, in order,
//  through the line store read, window, sums, products and round/saturate into the output register
//  the whole pipeline advances together; it stalls only while a result sits unclaimed
//  in the output register, and o_ready follows that condition
//  reset (synchronous, active low) clears counters, window and valid bits and loads default frame size and weights;
//  line stores are not cleared, their entries are always written before use
//  writing frame_size restarts the frame at row 0, column 0
`timescale 1ns / 1ps
`default_nettype none
module symmetric_3x3_smoothing (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // pixel input transaction
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [sm3_pkg::PIX_W-1:0]  i_pixel,
    // result transaction
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [sm3_pkg::PIX_W-1:0]  o_smoothed,
    output logic      [sm3_pkg::CNT_W-1:0]  o_out_row,
    output logic      [sm3_pkg::CNT_W-1:0]  o_out_col,
    output logic                            o_frame_last,
    // register writes
    input  wire logic                       i_cfg_we,
    input  wire logic [sm3_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sm3_pkg::DATA_W-1:0] i_cfg_data
);
    import sm3_pkg::*;

    // configuration registers
    logic [FSZ_W-1:0]  r_frame_size;
    t_weights          r_wgt;

    // effective frame edge, clamped to the supported range, minus one
    logic [SIZE_W-1:0] eff_size;
    logic [CNT_W-1:0]  eff_last;

    // raster position of the next pixel
    logic [CNT_W-1:0]  r_row, n_row;
    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  cur_row;
    logic [CNT_W-1:0]  cur_col;

    // handshake
    logic              accept;
    logic              pipe_en;
    logic              mac_vld;

    // stage 1: line store read data is valid here
    logic              r_s1_vld;
    t_pix              r_s1_px;
    logic [ADDR_W-1:0] r_s1_col;
    logic              r_s1_prod;
    t_meta             r_s1_meta;
    t_pix              up_rd;
    t_pix              mid_rd;

    // stage 2: window holds the neighborhood of the pixel in r_s2_meta
    t_win              r_win, n_win;
    logic              r_s2_vld;
    t_meta             r_s2_meta;

    t_meta             out_meta;

    always_comb begin
        if (32'(r_frame_size) < MIN_SIZE) begin
            eff_size = SIZE_W'(MIN_SIZE);
        end else if (32'(r_frame_size) > MAX_SIZE) begin
            eff_size = SIZE_W'(MAX_SIZE);
        end else begin
            eff_size = SIZE_W'(r_frame_size);
        end
        eff_last = CNT_W'(eff_size - SIZE_W'(1));
    end

    // the whole pipeline moves unless a result waits in the output register
    assign pipe_en = !o_valid || i_ready;
    assign o_ready = pipe_en;
    assign accept  = i_valid && pipe_en;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= RST_FRAME_SIZE;
            r_wgt.corner <= RST_CORNER;
            r_wgt.orth   <= RST_ORTH;
            r_wgt.center <= RST_CENTER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_SIZE: r_frame_size <= i_cfg_data[FSZ_W-1:0];
                REG_CORNER:     r_wgt.corner <= i_cfg_data[WGT_W-1:0];
                REG_ORTH:       r_wgt.orth   <= i_cfg_data[WGT_W-1:0];
                REG_CENTER:     r_wgt.center <= i_cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // position counters, with a guard in case the frame shrank
    always_comb begin
        if (r_row > eff_last || r_col > eff_last) begin
            cur_row = '0;
            cur_col = '0;
        end else begin
            cur_row = r_row;
            cur_col = r_col;
        end
        if (cur_col == eff_last) begin
            n_col = '0;
            n_row = (cur_row == eff_last) ? '0 : cur_row + CNT_W'(1);
        end else begin
            n_col = cur_col + CNT_W'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cfg_we && i_cfg_idx == REG_FRAME_SIZE) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // stage 1 capture: pixel, column address and result tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px        <= i_pixel;
            r_s1_col       <= ADDR_W'(cur_col);
            r_s1_prod      <= (cur_row >= CNT_W'(2)) && (cur_col >= CNT_W'(2));
            r_s1_meta.row  <= cur_row - CNT_W'(1);
            r_s1_meta.col  <= cur_col - CNT_W'(1);
            r_s1_meta.last <= (cur_row == eff_last) && (cur_col == eff_last);
        end
    end

    // line stores: read at accept, written back from stage 1 when the pipe moves, with the shifted lines
    sm3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SIZE)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (pipe_en && r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata (mid_rd),
        .i_re    (accept),
        .i_raddr (ADDR_W'(cur_col)),
        .o_rdata (up_rd)
    );

    sm3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SIZE)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (pipe_en && r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (accept),
        .i_raddr (ADDR_W'(cur_col)),
        .o_rdata (mid_rd)
    );

    // window shifts left one column and takes the new column on the right
    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = up_rd;
        n_win[1][2] = mid_rd;
        n_win[2][2] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_s2_vld <= 1'b0;
        end else if (pipe_en) begin
            r_s2_vld <= r_s1_vld && r_s1_prod;
            if (r_s1_vld) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    // sums, products, rounding and the output register
    sm3_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_vld      (r_s2_vld),
        .i_win      (r_win),
        .i_meta     (r_s2_meta),
        .i_wgt      (r_wgt),
        .o_valid    (mac_vld),
        .o_smoothed (o_smoothed),
        .o_meta     (out_meta)
    );

    assign o_valid      = mac_vld;
    assign o_out_row    = out_meta.row;
    assign o_out_col    = out_meta.col;
    assign o_frame_last = out_meta.last;

    // position counters never leave the frame
    a_cnt_in_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= eff_last) && (r_col <= eff_last))
        else $error("position counter beyond frame edge");

    // only interior pixels produce results
    a_interior : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_row != '0) && (o_out_col != '0))
        else $error("result tagged with a border position");

    // the last result of a square frame sits on the diagonal
    a_last_diag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |-> (o_out_row == o_out_col))
        else $error("frame_last off the diagonal");

    // when the pipe moves without an accepted pixel, stage 1 is left empty
    a_s1_from_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_en && !accept) |=> !r_s1_vld)
        else $error("stage 1 valid without an accepted pixel");

endmodule
`default_nettype wire
